FILE: hw/rtl/itp_pkg.sv
// Shared types, character codes and the precedence function for the
// infix-to-postfix converter. No dependencies.
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  // ASCII codes that the converter acts on
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // Sticky status codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef enum logic [2:0] {
    KIND_CHAR,
    KIND_OP,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_END
  } itp_kind_e;

  // Classified word handed from front to back
  typedef struct packed {
    itp_kind_e  kind;
    logic [7:0] sym;
    logic [1:0] prec;
  } itp_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_DEC,
    ST_PUSH,
    ST_DISC_RD,
    ST_DISC_LD,
    ST_SUMMARY
  } itp_state_e;

  // 0 means "not an operator"
  function automatic logic [1:0] prec_of(input logic [7:0] ch);
    logic [1:0] p;
    p = 2'd0;
    if (ch == CH_CARET) p = 2'd3;
    else if (ch == CH_STAR || ch == CH_SLASH) p = 2'd2;
    else if (ch == CH_PLUS || ch == CH_MINUS) p = 2'd1;
    return p;
  endfunction

endpackage

FILE: hw/rtl/infix_to_postfix_converter.sv
// Top level of the infix-to-postfix converter: front end with input queue
// and back end with operator stack. Depends on itp_pkg, itp_front, itp_back.
//
// Shunting-yard converter. Each input word is one infix character (tuser=0)
// or an end-of-expression mark (tuser=1). Plain characters leave as output
// words. Operators + - * / ^ (precedence 1,1,2,2,3, all left-associative)
// and '(' go onto a STACK_DEPTH-entry operator stack; an operator first pops
// entries off the top while they have equal or higher precedence, ')' pops
// up to the nearest '(' and drops it, and the end mark flushes the whole
// stack (leftover '(' included) and then emits a summary word with tuser=1,
// symbol zero and the sticky status (0 ok, 1 push onto a full stack, 2 stray
// ')'), after which the status clears. tlast marks the last word caused by an
// input word; on flush pops the status field reads 0. Each pop reads the
// stack memory, then decides and emits once the output register is free; a
// ')' that drops its '(' adds a discard read and load, a push after pops
// adds a push state. A two-word queue between front and back and a one-word
// output register decouple the sides.
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tuser_i,   // [0] mode (1 = end of expression)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_symbol, [9:8] status, rest 0
  output logic        m_axis_tlast_o,   // last_of_run
  output logic        m_axis_tuser_o    // [0] end_marker
);

  logic       cmd_valid;
  logic       cmd_ready;
  itp_cmd_t   cmd;
  logic [7:0] out_symbol;
  logic [1:0] out_status;

  itp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_mode_i   (s_axis_tuser_i),
    .in_symbol_i (s_axis_tdata_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_symbol_o (out_symbol),
    .out_last_o   (m_axis_tlast_o),
    .out_end_o    (m_axis_tuser_o),
    .out_status_o (out_status)
  );

  assign m_axis_tdata_o = {6'b0, out_status, out_symbol};

endmodule

FILE: hw/rtl/itp_front.sv
// Front end: accepts input words, classifies them and buffers them in a
// two-entry queue toward the back end. Depends on itp_pkg.
module itp_front import itp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     in_mode_i,
  input  logic [7:0] in_symbol_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output itp_cmd_t cmd_o
);

  localparam int unsigned QDepth = 2;

  itp_cmd_t   q_mem [QDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  itp_cmd_t   cls;
  logic       push, pop;

  always_comb begin
    cls.sym  = in_symbol_i;
    cls.prec = prec_of(in_symbol_i);
    if (in_mode_i) begin
      cls.kind = KIND_END;
    end else if (cls.prec != 2'd0) begin
      cls.kind = KIND_OP;
    end else if (in_symbol_i == CH_LPAREN) begin
      cls.kind = KIND_OPEN;
    end else if (in_symbol_i == CH_RPAREN) begin
      cls.kind = KIND_CLOSE;
    end else begin
      cls.kind = KIND_CHAR;
    end
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: hw/rtl/itp_back.sv
// Back end: operator stack in a memory, pop/push sequencer and output
// register. Depends on itp_pkg.
module itp_back import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  itp_cmd_t   cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       out_last_o,
  output logic       out_end_o,
  output logic [1:0] out_status_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);

  logic [7:0] stack_mem [STACK_DEPTH];
  logic [7:0] rd_q;
  logic [IW-1:0] rd_addr;

  itp_state_e state_q, state_d;
  itp_cmd_t   cmd_q, cmd_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] open_q, open_d;
  logic [1:0]  err_q, err_d;
  logic [1:0]  pop_stat_q, pop_stat_d;
  logic [7:0]  top_q, top_d;

  logic       ov_q, ov_d;
  logic [7:0] osym_q, osym_d;
  logic       olast_q, olast_d;
  logic       oend_q, oend_d;
  logic [1:0] ostat_q, ostat_d;

  logic        out_free;
  logic        we;
  logic [IW-1:0] waddr;
  logic [7:0]  wdata;
  logic [CW-1:0] new_cnt;
  logic        cont;
  logic        do_push;
  logic [7:0]  push_sym;

  assign out_free = !ov_q || out_ready_i;
  assign rd_addr  = IW'(count_q - CW'(2));
  assign new_cnt  = count_q - CW'(1);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    open_d     = open_q;
    err_d      = err_q;
    pop_stat_d = pop_stat_q;
    top_d      = top_q;
    ov_d       = ov_q && !out_ready_i;
    osym_d     = osym_q;
    olast_d    = olast_q;
    oend_d     = oend_q;
    ostat_d    = ostat_q;
    cmd_ready_o = 1'b0;
    do_push    = 1'b0;
    push_sym   = cmd_q.sym;
    cont       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.kind)
            KIND_CHAR: begin
              if (out_free) begin
                cmd_ready_o = 1'b1;
                ov_d    = 1'b1;
                osym_d  = cmd_i.sym;
                olast_d = 1'b1;
                oend_d  = 1'b0;
                ostat_d = err_q;
              end
            end
            KIND_OP: begin
              cmd_ready_o = 1'b1;
              pop_stat_d  = err_q;
              if (count_q != '0 && prec_of(top_q) >= cmd_i.prec) begin
                state_d = ST_POP_RD;
              end else begin
                do_push  = 1'b1;
                push_sym = cmd_i.sym;
              end
            end
            KIND_OPEN: begin
              cmd_ready_o = 1'b1;
              do_push  = 1'b1;
              push_sym = cmd_i.sym;
            end
            KIND_CLOSE: begin
              cmd_ready_o = 1'b1;
              // pops already carry the error this item ends with
              if (err_q != ERR_NONE) pop_stat_d = err_q;
              else if (open_q == '0) pop_stat_d = ERR_UNMATCHED;
              else pop_stat_d = ERR_NONE;
              if (count_q == '0) begin
                if (err_q == ERR_NONE) err_d = ERR_UNMATCHED;
              end else if (top_q == CH_LPAREN) begin
                state_d = ST_DISC_RD;
              end else begin
                state_d = ST_POP_RD;
              end
            end
            KIND_END: begin
              cmd_ready_o = 1'b1;
              pop_stat_d  = ERR_NONE;   // error clears at end of item
              state_d = (count_q != '0) ? ST_POP_RD : ST_SUMMARY;
            end
            default: begin
              cmd_ready_o = 1'b1;
            end
          endcase
        end
      end

      ST_POP_RD: begin
        state_d = ST_POP_DEC;
      end

      ST_POP_DEC: begin
        case (cmd_q.kind)
          KIND_OP:    cont = (new_cnt != '0) && (prec_of(rd_q) >= cmd_q.prec);
          KIND_CLOSE: cont = (new_cnt != '0) && (rd_q != CH_LPAREN);
          KIND_END:   cont = (new_cnt != '0);
          default:    cont = 1'b0;
        endcase
        if (out_free) begin
          ov_d    = 1'b1;
          osym_d  = top_q;
          olast_d = (cmd_q.kind != KIND_END) && !cont;
          oend_d  = 1'b0;
          ostat_d = pop_stat_q;
          count_d = new_cnt;
          top_d   = rd_q;
          if (top_q == CH_LPAREN) open_d = open_q - CW'(1);
          if (cont) begin
            state_d = ST_POP_RD;
          end else begin
            case (cmd_q.kind)
              KIND_OP: state_d = ST_PUSH;
              KIND_CLOSE: begin
                if (new_cnt != '0) begin
                  state_d = ST_DISC_RD;
                end else begin
                  state_d = ST_IDLE;
                  if (err_q == ERR_NONE) err_d = ERR_UNMATCHED;
                end
              end
              KIND_END: state_d = ST_SUMMARY;
              default:  state_d = ST_IDLE;
            endcase
          end
        end
      end

      ST_PUSH: begin
        do_push = 1'b1;
        state_d = ST_IDLE;
      end

      ST_DISC_RD: begin
        state_d = ST_DISC_LD;
      end

      ST_DISC_LD: begin
        count_d = new_cnt;
        open_d  = open_q - CW'(1);
        top_d   = rd_q;
        state_d = ST_IDLE;
      end

      ST_SUMMARY: begin
        if (out_free) begin
          ov_d    = 1'b1;
          osym_d  = 8'h00;
          olast_d = 1'b1;
          oend_d  = 1'b1;
          ostat_d = err_q;
          err_d   = ERR_NONE;
          open_d  = '0;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // push onto the stack, or flag overflow when full
    we    = 1'b0;
    waddr = IW'(count_q);
    wdata = push_sym;
    if (do_push) begin
      if (count_q == CW'(STACK_DEPTH)) begin
        if (err_q == ERR_NONE) err_d = ERR_OVERFLOW;
      end else begin
        we      = 1'b1;
        top_d   = push_sym;
        count_d = count_q + CW'(1);
        if (push_sym == CH_LPAREN) open_d = open_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      open_q     <= '0;
      err_q      <= ERR_NONE;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      open_q     <= open_d;
      err_q      <= err_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pop_stat_q <= pop_stat_d;
    top_q      <= top_d;
    osym_q     <= osym_d;
    olast_q    <= olast_d;
    oend_q     <= oend_d;
    ostat_q    <= ostat_d;
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    rd_q <= stack_mem[rd_addr];
  end

  assign out_valid_o  = ov_q;
  assign out_symbol_o = osym_q;
  assign out_last_o   = olast_q;
  assign out_end_o    = oend_q;
  assign out_status_o = ostat_q;

endmodule
